>>> rtl/swmmm_pkg.sv
// Shared constants and controller/datapath interface types for the
// sliding window min/max/mean block. No dependencies.
`timescale 1ns / 1ps

package swmmm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int HELD_W     = 7;
  localparam int WINDOW_DEF = 120;
  localparam int QUO_W      = 16;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic take;      // capture incoming sample, write store, advance pointer
    logic clear;     // empty the window
    logic rd;        // read store at scan index, advance index
    logic div_init;  // load divider from window sum
    logic div_step;  // one restoring division step
    logic out_load;  // load statistics into output register
    logic out_zero;  // load zeros into output register
  } swmmm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_last;   // scan index at last stored sample
    logic div_last;  // final division step
  } swmmm_sts_t;

endpackage

>>> rtl/swmmm_ctrl.sv
// Controller for the sliding window min/max/mean block: sequences
// store scan, division and output handoff. Depends on swmmm_pkg.
`timescale 1ns / 1ps

module swmmm_ctrl
  import swmmm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  output logic       out_valid,
  input  logic       out_ready,
  output swmmm_cmd_t cmd,
  input  swmmm_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DRAIN, S_DINIT, S_DIV, S_OUT, S_ZERO
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_CLEAR) begin
            cmd.clear = 1'b1;
            state_nxt = S_ZERO;
          end else begin
            cmd.take  = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        if (sts.rd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      // last read data accumulates here
      S_DRAIN: state_nxt = S_DINIT;
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ZERO: begin
        if (slot_free) begin
          cmd.out_zero  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/swmmm_dp.sv
// Datapath for the sliding window min/max/mean block: sample store,
// pointers, min/max/sum accumulators, serial divider, output register.
// Depends on swmmm_pkg.
`timescale 1ns / 1ps

module swmmm_dp
  import swmmm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  swmmm_cmd_t                 cmd,
  output swmmm_sts_t                 sts,
  output logic signed [SAMPLE_W-1:0] out_current,
  output logic signed [SAMPLE_W-1:0] out_minimum,
  output logic signed [SAMPLE_W-1:0] out_maximum,
  output logic signed [SAMPLE_W-1:0] out_average,
  output logic        [HELD_W-1:0]   out_samples_held
);

  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = CNT_W + SAMPLE_W;
  localparam int DCNT_W = $clog2(QUO_W);

  logic signed [SAMPLE_W-1:0] mem [WINDOW];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       rd_vld_r;
  logic                       first_r;

  logic [PTR_W-1:0] wp_r, idx_r;
  logic [CNT_W-1:0] cnt_r;

  logic signed [SAMPLE_W-1:0] cur_r, min_r, max_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-1:0]    rd_ext;

  logic [CNT_W:0]      rem_r;
  logic [QUO_W-1:0]    quo_r;
  logic [DCNT_W-1:0]   dcnt_r;
  logic                neg_r;
  logic [SUM_W-1:0]    abs_sum;
  logic [CNT_W:0]      rem_sh;
  logic [CNT_W:0]      trial;
  logic                fits;
  logic [QUO_W-1:0]    avg_mag;

  assign rd_ext  = {{(SUM_W-SAMPLE_W){rd_data_r[SAMPLE_W-1]}}, rd_data_r};
  assign abs_sum = sum_r[SUM_W-1] ? (SUM_W)'(-sum_r) : sum_r;
  assign rem_sh  = {rem_r[CNT_W-1:0], quo_r[QUO_W-1]};
  assign trial   = rem_sh - {1'b0, cnt_r};
  assign fits    = (rem_sh >= {1'b0, cnt_r});
  assign avg_mag = neg_r ? (QUO_W)'(-quo_r) : quo_r;

  assign sts.rd_last  = (idx_r == PTR_W'(cnt_r - CNT_W'(1)));
  assign sts.div_last = (dcnt_r == DCNT_W'(QUO_W - 1));

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[wp_r] <= in_sample;
    end
    rd_data_r <= mem[idx_r];
  end

  // control state: pointers, fill count, scan flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      first_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.clear) begin
        wp_r  <= '0;
        cnt_r <= '0;
      end else if (cmd.take) begin
        wp_r <= (wp_r == PTR_W'(WINDOW - 1)) ? '0 : wp_r + PTR_W'(1);
        if (cnt_r != CNT_W'(WINDOW)) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (cmd.take) begin
        idx_r   <= '0;
        first_r <= 1'b1;
      end else begin
        if (cmd.rd) begin
          idx_r <= idx_r + PTR_W'(1);
        end
        if (rd_vld_r) begin
          first_r <= 1'b0;
        end
      end
    end
  end

  // accumulators, divider and output register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_r <= in_sample;
    end
    if (rd_vld_r) begin
      if (first_r) begin
        min_r <= rd_data_r;
        max_r <= rd_data_r;
        sum_r <= rd_ext;
      end else begin
        if (rd_data_r < min_r) min_r <= rd_data_r;
        if (rd_data_r > max_r) max_r <= rd_data_r;
        sum_r <= sum_r + rd_ext;
      end
    end
    if (cmd.div_init) begin
      // high part is below the count, so sixteen steps cover the quotient
      rem_r  <= {1'b0, abs_sum[SUM_W-1:QUO_W]};
      quo_r  <= abs_sum[QUO_W-1:0];
      neg_r  <= sum_r[SUM_W-1];
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= fits ? trial : rem_sh;
      quo_r  <= {quo_r[QUO_W-2:0], fits};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.out_load) begin
      out_current      <= cur_r;
      out_minimum      <= min_r;
      out_maximum      <= max_r;
      out_average      <= avg_mag;
      out_samples_held <= HELD_W'(cnt_r);
    end else if (cmd.out_zero) begin
      out_current      <= '0;
      out_minimum      <= '0;
      out_maximum      <= '0;
      out_average      <= '0;
      out_samples_held <= '0;
    end
  end

endmodule

>>> rtl/sliding_window_min_max_mean.sv
// Sliding window min/max/mean over signed 16-bit samples.
// After a sample transaction is accepted the block reads every stored sample,
// drains the last read, loads the divider, runs 16 divider steps and loads
// the output register, raising out_valid; a clear transaction loads zeros.
// Either load waits for a free output slot; in_ready is low until then.
// Reset (rst_n low, synchronous) empties the window; store is not cleared.
`timescale 1ns / 1ps

module sliding_window_min_max_mean
  import swmmm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_current,
  output logic signed [SAMPLE_W-1:0] out_minimum,
  output logic signed [SAMPLE_W-1:0] out_maximum,
  output logic signed [SAMPLE_W-1:0] out_average,
  output logic        [HELD_W-1:0]   out_samples_held
);

  swmmm_cmd_t cmd;
  swmmm_sts_t sts;

  swmmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  swmmm_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_sample        (in_sample),
    .cmd              (cmd),
    .sts              (sts),
    .out_current      (out_current),
    .out_minimum      (out_minimum),
    .out_maximum      (out_maximum),
    .out_average      (out_average),
    .out_samples_held (out_samples_held)
  );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for sliding_window_min_max_mean: named tests drive sample
// and clear transactions, and a window predictor checks every result field.
// Depends on swmmm_pkg and the sliding_window_min_max_mean RTL.
`timescale 1ns / 1ps

module testbench
  import swmmm_pkg::*;
();

  localparam int WINDOW   = WINDOW_DEF;
  localparam int LOG_CAP  = 100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] current;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SAMPLE_W-1:0] average;
    logic [HELD_W-1:0]          held;
  } window_stats_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_kind;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_current;
  logic signed [SAMPLE_W-1:0] out_minimum;
  logic signed [SAMPLE_W-1:0] out_maximum;
  logic signed [SAMPLE_W-1:0] out_average;
  logic [HELD_W-1:0]          out_samples_held;

  // predictor state
  logic signed [SAMPLE_W-1:0] ring_store [WINDOW];
  int                         ring_wr_idx;
  int                         ring_fill;
  window_stats_t              pending_stats [$];

  int error_count = 0;
  bit src_idle    = 1'b0;
  bit snk_idle    = 1'b0;
  int sink_hold   = 0;

  sliding_window_min_max_mean #(.WINDOW(WINDOW)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_current      (out_current),
    .out_minimum      (out_minimum),
    .out_maximum      (out_maximum),
    .out_average      (out_average),
    .out_samples_held (out_samples_held)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (error_count < LOG_CAP)
      $display("MISMATCH @%0t: %s", $time, what);
    error_count++;
  endtask

  // Update the window copy for one accepted transaction and queue its statistics.
  task automatic predict_window(input logic kind, input logic signed [SAMPLE_W-1:0] value);
    window_stats_t st;
    int            lo;
    int            hi;
    int            total;
    if (kind == KIND_CLEAR) begin
      ring_wr_idx = 0;
      ring_fill   = 0;
      st          = '0;
    end else begin
      ring_store[ring_wr_idx] = value;
      ring_wr_idx = (ring_wr_idx == WINDOW - 1) ? 0 : ring_wr_idx + 1;
      if (ring_fill < WINDOW)
        ring_fill++;
      lo    = ring_store[0];
      hi    = ring_store[0];
      total = 0;
      for (int i = 0; i < ring_fill; i++) begin
        if (ring_store[i] < lo)
          lo = ring_store[i];
        if (ring_store[i] > hi)
          hi = ring_store[i];
        total += ring_store[i];
      end
      st.current = value;
      st.minimum = SAMPLE_W'(lo);
      st.maximum = SAMPLE_W'(hi);
      st.average = SAMPLE_W'(total / ring_fill);  // truncates toward zero
      st.held    = HELD_W'(ring_fill);
    end
    pending_stats.push_back(st);
  endtask

  // Offer one transaction and hold it until accepted.
  task automatic send_item(input logic kind, input logic signed [SAMPLE_W-1:0] value);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sample <= value;
    do @(posedge clk); while (!in_ready);
    predict_window(kind, value);
  endtask

  // Stop offering and wait until every queued result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      3:       return SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Receiver: random ready bursts, plus a long hold-off when one is requested.
  initial begin : sink
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else if (snk_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    window_stats_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("result transaction with no expectation waiting");
      end else begin
        want = pending_stats.pop_front();
        check_field("current", out_current, want.current);
        check_field("minimum", out_minimum, want.minimum);
        check_field("maximum", out_maximum, want.maximum);
        check_field("average", out_average, want.average);
        check_field("samples_held", out_samples_held, want.held);
      end
    end
  end

  // Field extremes, clears (empty and with a live sample field), truncation of the mean.
  task automatic test_field_extremes();
    logic signed [SAMPLE_W-1:0] seq [] = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1};
    foreach (seq[i])
      send_item(KIND_SAMPLE, seq[i]);
    send_item(KIND_CLEAR, 16'sh7fff);
    send_item(KIND_CLEAR, 16'sh8000);
    send_item(KIND_SAMPLE, -16'sd1);
    send_item(KIND_SAMPLE, -16'sd2);   // mean -3/2 -> -1
    send_item(KIND_SAMPLE, -16'sd4);   // mean -7/3 -> -2
    send_item(KIND_CLEAR, 16'sh5555);
    send_item(KIND_SAMPLE, 16'sd1);
    send_item(KIND_SAMPLE, 16'sd2);    // mean 3/2 -> 1
    send_item(KIND_SAMPLE, 16'sh8000);
    send_item(KIND_SAMPLE, 16'sh7fff);
    send_item(KIND_SAMPLE, 16'shaaaa);
    send_item(KIND_CLEAR, 16'shffff);
    drain_results();
  endtask

  // Fill the window past its depth with extreme values so the oldest are overwritten.
  task automatic test_window_wrap();
    send_item(KIND_CLEAR, 16'sh0000);
    for (int i = 0; i < WINDOW + 5; i++)
      send_item(KIND_SAMPLE, (i < WINDOW / 2) ? 16'sh8000 : 16'sh7fff);
    for (int i = 0; i < 10; i++)
      send_item(KIND_SAMPLE, pick_sample());
    drain_results();
  endtask

  // Hold the result side off while transactions keep coming, then pause until drained.
  task automatic test_output_backpressure();
    sink_hold = 400;
    for (int i = 0; i < 12; i++)
      send_item(KIND_SAMPLE, pick_sample());
    drain_results();
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0)
        send_item(KIND_CLEAR, SAMPLE_W'($urandom()));
      else
        send_item(KIND_SAMPLE, pick_sample());
    end
    drain_results();
  endtask

  initial begin : main
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_kind   <= KIND_SAMPLE;
    in_sample <= '0;
    ring_wr_idx = 0;
    ring_fill   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    test_window_wrap();
    test_output_backpressure();
    test_random_traffic(550);
    // steady stream with no idling on either side
    src_idle = 1'b0;
    snk_idle = 1'b0;
    test_random_traffic(100);

    repeat (160) @(posedge clk);
    if (error_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
